[sv/box_downsample_gray_rgb565_unit_macros.svh]
// Assertion macros used by the checker file.
`ifndef BOX_DOWNSAMPLE_GRAY_RGB565_UNIT_MACROS_SVH
`define BOX_DOWNSAMPLE_GRAY_RGB565_UNIT_MACROS_SVH

// check outside reset
`define BDG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("%m failed");

// check at every edge, reset included
`define BDG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("%m failed");

`endif

[sv/bdg_pkg.sv]
// Shared types and constants of the box downsampler.
package bdg_pkg;

  localparam int unsigned MaxOutWidth = 256;
  localparam int unsigned AddrW       = $clog2(MaxOutWidth);
  localparam int unsigned CoordW      = 12;
  localparam int unsigned SumW        = 32;
  localparam int unsigned CntW        = 2 * CoordW;
  localparam int unsigned OwW         = 9;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_OUT_W = 2'd2;
  localparam logic [1:0] REG_OUT_H = 2'd3;

  typedef enum logic [2:0] {
    OP_BW,
    OP_BH,
    OP_BX,
    OP_BY,
    OP_AVG
  } op_e;

  typedef enum logic [2:0] {
    ST_DGO,
    ST_DWAIT,
    ST_IDLE,
    ST_RD,
    ST_ACC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic emit_err;
    logic skip;
    logic acc;
    logic div_start;
    logic div_latch;
    op_e  op;
    logic emit_avg;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic size_err;
    logic in_range;
    logic last;
    logic out_busy;
  } status_t;

endpackage

[sv/box_downsample_gray_rgb565_unit.sv]
// Top level of the box downsampler from gray samples to RGB565.
// Input stream: one 10-bit sample per item in raster order, tuser marks the
// first sample of a frame. Output stream: one RGB565 block average with its
// output column and row; tlast marks the bottom-right block, tuser flags a
// size error (data then zero). Config channel writes source and output sizes.
// After reset or any config write the block computes block sizes and realigns
// the position with the shared divider; samples are not taken meanwhile.
// A sample inside a block passes through accept, sum read and sum write. The
// last sample of a block adds the average divide, then the result is loaded
// into the output register. Samples in leftover columns or rows pass through
// accept and sum read only; with invalid sizes each accepted sample loads an
// error result into the output register. The output register holds while the
// receiver stalls, and with valid sizes the next sample is still taken; a
// further result waits for the slot.
// Reset restores default sizes; column sums are undefined until written.
module box_downsample_gray_rgb565_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample[9:0], zero pad
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // color[15:0], out_x[23:16], out_y[35:24], pad
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // size_error
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [11:0] cfg_data_i
);

  bdg_pkg::cmd_t    cmd;
  bdg_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  bdg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bdg_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_valid_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (s_axis_tdata[9:0]),
    .frame_start_i (s_axis_tuser),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast),
    .out_err_o     (m_axis_tuser)
  );

endmodule

[sv/bdg_ram.sv]
// Generic single-port RAM with registered read.
module bdg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[sv/bdg_div.sv]
// Restoring divider, one quotient bit per cycle.
module bdg_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bdg_pkg::SumW-1:0]  dividend_i,
  input  logic [bdg_pkg::CntW-1:0]  divisor_i,
  output logic                      busy_o,
  output logic [bdg_pkg::SumW-1:0]  quot_o,
  output logic [bdg_pkg::CntW-1:0]  rem_o
);

  localparam int unsigned StepW = $clog2(bdg_pkg::SumW + 1);

  logic [bdg_pkg::SumW-1:0] q_q;
  logic [bdg_pkg::CntW-1:0] rem_q, dvs_q, rem_d;
  logic [bdg_pkg::CntW:0]   trial;
  logic                     bit_d;
  logic [StepW-1:0]         step_q;

  always_comb begin
    trial = {rem_q, q_q[bdg_pkg::SumW-1]};
    bit_d = trial >= {1'b0, dvs_q};
    rem_d = bit_d ? bdg_pkg::CntW'(trial - {1'b0, dvs_q}) : trial[bdg_pkg::CntW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= StepW'(bdg_pkg::SumW);
    end else if (step_q != '0) begin
      step_q <= step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (step_q != '0) begin
      q_q   <= {q_q[bdg_pkg::SumW-2:0], bit_d};
      rem_q <= rem_d;
    end
  end

  assign busy_o = step_q != '0;
  assign quot_o = q_q;
  assign rem_o  = rem_q;

endmodule

[sv/bdg_datapath.sv]
// Datapath: settings, position counters, column sums, divider and output register.
module bdg_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bdg_pkg::cmd_t          cmd_i,
  output bdg_pkg::status_t       status_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_addr_i,
  input  logic [11:0]            cfg_data_i,
  input  logic [9:0]             sample_i,
  input  logic                   frame_start_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [39:0]            out_data_o,
  output logic                   out_last_o,
  output logic                   out_err_o
);

  localparam int unsigned CW = bdg_pkg::CoordW;

  logic [CW-1:0] sw_q, sh_q, oh_q;
  logic [bdg_pkg::OwW-1:0] ow_q;
  logic [CW-1:0] bw_q, bh_q, col_q, row_q, dx_q, bx_q, dy_q, by_q;
  logic [bdg_pkg::CntW-1:0] cnt_q;
  logic [9:0]    sample_q;
  logic [bdg_pkg::SumW-1:0] sum_q, sum_d, rdata;
  logic [CW-1:0] ow_ext, nxt_col, nxt_row;
  logic          wrap_c, wrap_r;

  logic [bdg_pkg::SumW-1:0] dvd;
  logic [bdg_pkg::CntW-1:0] dvs, rem;
  logic [bdg_pkg::SumW-1:0] quot;
  logic          busy;

  logic          out_valid_q;
  logic [15:0]   color_q;
  logic [7:0]    ox_q;
  logic [CW-1:0] oy_q;
  logic          fd_q, err_q;
  logic [7:0]    res_x_q;
  logic [CW-1:0] res_y_q;
  logic          res_last_q;
  logic [7:0]    avg;

  assign ow_ext  = {3'b0, ow_q};
  assign nxt_col = col_q + 1'b1;
  assign nxt_row = row_q + 1'b1;
  assign wrap_c  = (nxt_col >= sw_q) || (nxt_col == '0);
  assign wrap_r  = (nxt_row >= sh_q) || (nxt_row == '0);

  always_comb begin
    unique case (cmd_i.op)
      bdg_pkg::OP_BW: begin
        dvd = bdg_pkg::SumW'(sw_q);
        dvs = bdg_pkg::CntW'(ow_q);
      end
      bdg_pkg::OP_BH: begin
        dvd = bdg_pkg::SumW'(sh_q);
        dvs = bdg_pkg::CntW'(oh_q);
      end
      bdg_pkg::OP_BX: begin
        dvd = bdg_pkg::SumW'(col_q);
        dvs = bdg_pkg::CntW'(bw_q);
      end
      bdg_pkg::OP_BY: begin
        dvd = bdg_pkg::SumW'(row_q);
        dvs = bdg_pkg::CntW'(bh_q);
      end
      default: begin
        dvd = sum_q;
        dvs = cnt_q;
      end
    endcase
  end

  bdg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .busy_o     (busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign sum_d = (dx_q == '0 && dy_q == '0) ? bdg_pkg::SumW'(sample_q)
                                            : rdata + bdg_pkg::SumW'(sample_q);

  bdg_ram #(
    .Width (bdg_pkg::SumW),
    .Depth (bdg_pkg::MaxOutWidth)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (cmd_i.acc),
    .addr_i  (bx_q[bdg_pkg::AddrW-1:0]),
    .wdata_i (sum_d),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= 12'd2592;
      sh_q <= 12'd1944;
      ow_q <= 9'd128;
      oh_q <= 12'd96;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bdg_pkg::REG_SRC_W: sw_q <= cfg_data_i;
        bdg_pkg::REG_SRC_H: sh_q <= cfg_data_i;
        bdg_pkg::REG_OUT_W: ow_q <= cfg_data_i[bdg_pkg::OwW-1:0];
        bdg_pkg::REG_OUT_H: oh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      dx_q  <= '0;
      bx_q  <= '0;
      dy_q  <= '0;
      by_q  <= '0;
    end else if (cmd_i.accept && frame_start_i) begin
      col_q <= '0;
      row_q <= '0;
      dx_q  <= '0;
      bx_q  <= '0;
      dy_q  <= '0;
      by_q  <= '0;
    end else if (cmd_i.div_latch && cmd_i.op == bdg_pkg::OP_BX) begin
      bx_q <= quot[CW-1:0];
      dx_q <= rem[CW-1:0];
    end else if (cmd_i.div_latch && cmd_i.op == bdg_pkg::OP_BY) begin
      by_q <= quot[CW-1:0];
      dy_q <= rem[CW-1:0];
    end else if (cmd_i.skip || cmd_i.acc) begin
      if (wrap_c) begin
        col_q <= '0;
        dx_q  <= '0;
        bx_q  <= '0;
        if (wrap_r) begin
          row_q <= '0;
          dy_q  <= '0;
          by_q  <= '0;
        end else begin
          row_q <= nxt_row;
          if (dy_q + 1'b1 == bh_q) begin
            dy_q <= '0;
            by_q <= by_q + 1'b1;
          end else begin
            dy_q <= dy_q + 1'b1;
          end
        end
      end else begin
        col_q <= nxt_col;
        if (dx_q + 1'b1 == bw_q) begin
          dx_q <= '0;
          bx_q <= bx_q + 1'b1;
        end else begin
          dx_q <= dx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_latch && cmd_i.op == bdg_pkg::OP_BW) begin
      bw_q <= quot[CW-1:0];
    end
    if (cmd_i.div_latch && cmd_i.op == bdg_pkg::OP_BH) begin
      bh_q  <= quot[CW-1:0];
      cnt_q <= bw_q * quot[CW-1:0];
    end
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
    if (cmd_i.acc) begin
      sum_q <= sum_d;
      oy_q  <= by_q;
      ox_q  <= bx_q[7:0];
      fd_q  <= (bx_q == ow_ext - 1'b1) && (by_q == oh_q - 1'b1);
    end
  end

  assign avg = quot[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_err || cmd_i.emit_avg) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_err) begin
      color_q <= '0;
      err_q   <= 1'b1;
    end else if (cmd_i.emit_avg) begin
      color_q    <= {avg[7:3], avg[7:2], avg[7:3]};
      res_x_q    <= ox_q;
      res_y_q    <= oy_q;
      res_last_q <= fd_q;
      err_q      <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_err_o   = err_q;
  assign out_last_o  = res_last_q & ~err_q;
  assign out_data_o  = err_q ? '0 : {4'b0, res_y_q, res_x_q, color_q};

  assign status_o.div_busy = busy;
  assign status_o.size_err = (sw_q == '0) || (sh_q == '0) || (ow_q == '0) || (oh_q == '0)
                          || (ow_q[8] && ow_q[7:0] != '0) || (bw_q == '0) || (bh_q == '0);
  assign status_o.in_range = (bx_q < ow_ext) && (by_q < oh_q);
  assign status_o.last     = (dx_q == bw_q - 1'b1) && (dy_q == bh_q - 1'b1);
  assign status_o.out_busy = out_valid_q && !out_ready_i;

endmodule

[sv/bdg_ctrl.sv]
// Controller: sequences size setup, sample accumulation, averaging and error results.
module bdg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bdg_pkg::status_t status_i,
  output bdg_pkg::cmd_t    cmd_o
);

  bdg_pkg::state_e state_q, state_d;
  bdg_pkg::op_e    op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdg_pkg::ST_DGO;
      op_q    <= bdg_pkg::OP_BW;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      bdg_pkg::ST_DGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = bdg_pkg::ST_DWAIT;
      end
      bdg_pkg::ST_DWAIT: begin
        if (!status_i.div_busy) begin
          cmd_o.div_latch = 1'b1;
          unique case (op_q)
            bdg_pkg::OP_BW: begin
              op_d    = bdg_pkg::OP_BH;
              state_d = bdg_pkg::ST_DGO;
            end
            bdg_pkg::OP_BH: begin
              op_d    = bdg_pkg::OP_BX;
              state_d = bdg_pkg::ST_DGO;
            end
            bdg_pkg::OP_BX: begin
              op_d    = bdg_pkg::OP_BY;
              state_d = bdg_pkg::ST_DGO;
            end
            bdg_pkg::OP_BY:  state_d = bdg_pkg::ST_IDLE;
            default:         state_d = bdg_pkg::ST_EMIT;
          endcase
        end
      end
      bdg_pkg::ST_IDLE: begin
        in_ready_o = !(status_i.size_err && status_i.out_busy);
        if (in_valid_i && in_ready_o) begin
          cmd_o.accept = 1'b1;
          if (status_i.size_err) begin
            cmd_o.emit_err = 1'b1;
          end else begin
            state_d = bdg_pkg::ST_RD;
          end
        end
      end
      bdg_pkg::ST_RD: begin
        if (status_i.in_range) begin
          state_d = bdg_pkg::ST_ACC;
        end else begin
          cmd_o.skip = 1'b1;
          state_d    = bdg_pkg::ST_IDLE;
        end
      end
      bdg_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (status_i.last) begin
          op_d    = bdg_pkg::OP_AVG;
          state_d = bdg_pkg::ST_DGO;
        end else begin
          state_d = bdg_pkg::ST_IDLE;
        end
      end
      bdg_pkg::ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit_avg = 1'b1;
          state_d        = bdg_pkg::ST_IDLE;
        end
      end
      default: state_d = bdg_pkg::ST_IDLE;
    endcase
    if (cfg_we_i) begin
      op_d    = bdg_pkg::OP_BW;
      state_d = bdg_pkg::ST_DGO;
    end
  end

endmodule

[sv/bdg_checker.sv]
// Port-level checker for the box downsampler and its bind.
`include "box_downsample_gray_rgb565_unit_macros.svh"

module bdg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  `BDG_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `BDG_ASSERT(a_err_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
  `BDG_ASSERT(a_cfg_busy, cfg_valid_i && cfg_ready_o |=> !s_axis_tready)
  `BDG_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !m_axis_tvalid)

endmodule

bind box_downsample_gray_rgb565_unit bdg_checker u_bdg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);
